@@ hdl/gl21_pkg.sv @@
// ----------------------------------------------------------------------------
// gl21_pkg
// Shared widths, register indexes and controller states for the grouped L2,1
// distance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gl21_pkg;

  localparam int unsigned LANES    = 4;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned ABS_W    = COORD_W;
  localparam int unsigned SQ_W     = 2 * ABS_W;
  localparam int unsigned SUMSQ_W  = SQ_W + 2;
  localparam int unsigned ROOT_W   = SUMSQ_W / 2;
  localparam int unsigned ITER_W   = $clog2(ROOT_W);
  localparam int unsigned SUM_W    = 40;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned IN_DW    = 2 * LANES * COORD_W + SUM_W + TAG_W;
  localparam int unsigned OUT_DW   = SUM_W + TAG_W;
  localparam int unsigned BOUND_LO = 2 * LANES * COORD_W;
  localparam int unsigned TAG_LO   = BOUND_LO + SUM_W;

  // configuration register indexes
  localparam logic REG_EARLY_EXIT = 1'b0;
  localparam logic REG_SQUARED    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_LAUNCH,
    ST_ROOT,
    ST_ACC
  } state_e;

endpackage

`default_nettype wire

@@ hdl/gl21_lane.sv @@
// ----------------------------------------------------------------------------
// gl21_lane
// One coordinate lane: absolute difference of query and point, squared and
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gl21_lane (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [gl21_pkg::COORD_W-1:0] query_i,
  input  wire logic [gl21_pkg::COORD_W-1:0] point_i,
  output logic [gl21_pkg::SQ_W-1:0]       sq_o
);

  logic signed [gl21_pkg::COORD_W:0] diff;
  logic        [gl21_pkg::COORD_W:0] mag;
  logic        [gl21_pkg::ABS_W-1:0] abs_val;
  logic        [gl21_pkg::SQ_W-1:0]  sq_q;

  always_comb begin
    diff = $signed({query_i[gl21_pkg::COORD_W-1], query_i})
         - $signed({point_i[gl21_pkg::COORD_W-1], point_i});
    mag  = diff[gl21_pkg::COORD_W] ? unsigned'(-diff) : unsigned'(diff);
    // magnitude never exceeds 2^COORD_W - 1
    abs_val = mag[gl21_pkg::ABS_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= abs_val * abs_val;
    end
  end

  assign sq_o = sq_q;

endmodule

`default_nettype wire

@@ hdl/gl21_merge.sv @@
// ----------------------------------------------------------------------------
// gl21_merge
// Adds the lane squares of one group into the group's sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module gl21_merge (
  input  wire logic                                         clk_i,
  input  wire logic                                         en_i,
  input  wire logic [gl21_pkg::LANES-1:0][gl21_pkg::SQ_W-1:0] sq_i,
  output logic [gl21_pkg::SUMSQ_W-1:0]                      sumsq_o
);

  logic [gl21_pkg::SUMSQ_W-1:0] total;
  logic [gl21_pkg::SUMSQ_W-1:0] sumsq_q;

  always_comb begin
    total = '0;
    for (int i = 0; i < gl21_pkg::LANES; i++) begin
      total = total + gl21_pkg::SUMSQ_W'(sq_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sumsq_q <= total;
    end
  end

  assign sumsq_o = sumsq_q;

endmodule

`default_nettype wire

@@ hdl/gl21_sqrt.sv @@
// ----------------------------------------------------------------------------
// gl21_sqrt
// Iterative floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gl21_sqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [gl21_pkg::SUMSQ_W-1:0]  x_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [gl21_pkg::ROOT_W-1:0]        root_o
);

  logic [gl21_pkg::SUMSQ_W-1:0] x_q, x_d;
  logic [gl21_pkg::SUMSQ_W-1:0] root_q, root_d;
  logic [gl21_pkg::ITER_W-1:0]  k_q, k_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [gl21_pkg::SUMSQ_W-1:0] bit_val;
  logic [gl21_pkg::SUMSQ_W-1:0] trial;

  always_comb begin
    bit_val = {{(gl21_pkg::SUMSQ_W-1){1'b0}}, 1'b1} << {k_q, 1'b0};
    trial   = root_q + bit_val;
    x_d     = x_q;
    root_d  = root_q;
    k_d     = k_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      x_d    = x_i;
      root_d = '0;
      k_d    = gl21_pkg::ITER_W'(gl21_pkg::ROOT_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (x_q >= trial) begin
        x_d    = x_q - trial;
        root_d = (root_q >> 1) + bit_val;
      end else begin
        root_d = root_q >> 1;
      end
      k_d = k_q - 1'b1;
      if (k_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    root_q <= root_d;
    k_q    <= k_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q[gl21_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

@@ hdl/grouped_l21_distance_unit.sv @@
// ----------------------------------------------------------------------------
// grouped_l21_distance_unit
// L2,1 mixed-norm distance between a query vector and a stored point, one
// 4-D group per input item, with early exit against a per-item bound.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one group: both vectors' four coordinates, the bound and
//   the point tag in tdata, the last-group mark in tlast. m_axis returns the
//   distance and tag in tdata and the exceeded flag in tuser, at most one
//   item per input item. cfg (always ready) writes early_exit_enable (index 0)
//   and squared_mode (index 1): the user must write it while idle (unchecked).
// Timing:
//   a group passes the lane registers and the merge adder, then launches the
//   shared bit-serial square root and waits for its result before the
//   accumulate step; in squared mode it goes from the merge adder straight
//   to the accumulate step. No new item is taken while a group is in work;
//   the next one can be taken in the cycle after the accumulate step ends.
//   Items absorbed after an early exit are taken one per cycle.
// Reset:
//   clears the running sum, the absorb flag and the output valid flag;
//   early exit enabled, squared mode off.
// Stall:
//   a result waits in the output register; a new item can be accepted and
//   worked on meanwhile, and holds in the accumulate step if it has a result.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_l21_distance_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // query_x0..3, point_x0..3, bound, point_tag (lowest bit up)
  input  wire logic [gl21_pkg::IN_DW-1:0]  s_axis_tdata,
  input  wire logic                        s_axis_tlast,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // distance, result_tag (lowest bit up)
  output logic [gl21_pkg::OUT_DW-1:0]      m_axis_tdata,
  // exceeded
  output logic                             m_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic                        cfg_index_i,
  input  wire logic                        cfg_data_i
);

  gl21_pkg::state_e state_q, state_d;

  logic                                      early_q, squared_q;
  logic                                      skipping_q, skipping_d;
  logic [gl21_pkg::SUM_W-1:0]                run_q, run_d;
  logic [gl21_pkg::SUM_W-1:0]                bound_q;
  logic [gl21_pkg::TAG_W-1:0]                tag_q;
  logic                                      last_q;
  logic                                      out_valid_q, out_valid_d;
  logic [gl21_pkg::SUM_W-1:0]                out_dist_q;
  logic                                      out_exc_q;
  logic [gl21_pkg::TAG_W-1:0]                out_tag_q;

  logic                                      in_accept;
  logic                                      lane_en;
  logic                                      merge_en;
  logic                                      sqrt_start;
  logic                                      sqrt_busy;
  logic                                      sqrt_done;
  logic [gl21_pkg::ROOT_W-1:0]               root;
  logic [gl21_pkg::LANES-1:0][gl21_pkg::SQ_W-1:0] lane_sq;
  logic [gl21_pkg::SUMSQ_W-1:0]              sumsq;

  logic [gl21_pkg::SUM_W-1:0]                add_val;
  logic [gl21_pkg::SUM_W:0]                  sum_wide;
  logic [gl21_pkg::SUM_W-1:0]                sum_sat;
  logic                                      hit;
  logic                                      produce;
  logic                                      out_load;
  logic                                      acc_done;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  // ---- lanes, merge, root ----
  for (genvar g = 0; g < gl21_pkg::LANES; g++) begin : g_lane
    gl21_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (lane_en),
      .query_i (s_axis_tdata[g*gl21_pkg::COORD_W +: gl21_pkg::COORD_W]),
      .point_i (s_axis_tdata[(gl21_pkg::LANES+g)*gl21_pkg::COORD_W +: gl21_pkg::COORD_W]),
      .sq_o    (lane_sq[g])
    );
  end

  gl21_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (merge_en),
    .sq_i    (lane_sq),
    .sumsq_o (sumsq)
  );

  gl21_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (sumsq),
    .busy_o  (sqrt_busy),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // ---- accumulate and decide ----
  always_comb begin
    add_val  = squared_q ? gl21_pkg::SUM_W'(sumsq) : gl21_pkg::SUM_W'(root);
    sum_wide = {1'b0, run_q} + {1'b0, add_val};
    sum_sat  = sum_wide[gl21_pkg::SUM_W] ? '1 : sum_wide[gl21_pkg::SUM_W-1:0];
    hit      = early_q && (sum_sat > bound_q);
    produce  = hit || last_q;
    acc_done = (state_q == gl21_pkg::ST_ACC) && !(produce && out_valid_q && !m_axis_tready);
  end

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      gl21_pkg::ST_IDLE: begin
        if (in_accept && !skipping_q) state_d = gl21_pkg::ST_MERGE;
      end
      gl21_pkg::ST_MERGE: begin
        state_d = squared_q ? gl21_pkg::ST_ACC : gl21_pkg::ST_LAUNCH;
      end
      gl21_pkg::ST_LAUNCH: begin
        state_d = gl21_pkg::ST_ROOT;
      end
      gl21_pkg::ST_ROOT: begin
        if (sqrt_done) state_d = gl21_pkg::ST_ACC;
      end
      gl21_pkg::ST_ACC: begin
        if (acc_done) state_d = gl21_pkg::ST_IDLE;
      end
      default: state_d = gl21_pkg::ST_IDLE;
    endcase
  end

  // ---- outputs of the controller ----
  always_comb begin
    s_axis_tready = (state_q == gl21_pkg::ST_IDLE);
    lane_en       = in_accept && !skipping_q;
    merge_en      = (state_q == gl21_pkg::ST_MERGE);
    sqrt_start    = (state_q == gl21_pkg::ST_LAUNCH);
    out_load      = acc_done && produce;
    skipping_d    = skipping_q;
    run_d         = run_q;
    if (in_accept && skipping_q && s_axis_tlast) begin
      skipping_d = 1'b0;
    end
    if (acc_done) begin
      run_d = produce ? '0 : sum_sat;
      // absorb the rest of the vector pair after an early exit
      skipping_d = hit && !last_q;
    end
    out_valid_d = out_load || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gl21_pkg::ST_IDLE;
      early_q     <= 1'b1;
      squared_q   <= 1'b0;
      skipping_q  <= 1'b0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      skipping_q  <= skipping_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          gl21_pkg::REG_EARLY_EXIT: early_q   <= cfg_data_i;
          gl21_pkg::REG_SQUARED:    squared_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      bound_q <= s_axis_tdata[gl21_pkg::BOUND_LO +: gl21_pkg::SUM_W];
      tag_q   <= s_axis_tdata[gl21_pkg::TAG_LO +: gl21_pkg::TAG_W];
      last_q  <= s_axis_tlast;
    end
    if (out_load) begin
      out_dist_q <= sum_sat;
      out_exc_q  <= hit;
      out_tag_q  <= tag_q;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_tag_q, out_dist_q};
  assign m_axis_tuser  = out_exc_q;

  // ---- assertions ----
  a_done_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> (state_q == gl21_pkg::ST_ROOT))
    else $error("root finished outside the root wait state");

  a_start_idle_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_start |-> !sqrt_busy)
    else $error("root unit started while busy");

  a_skip_after_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skipping_q) |-> (m_axis_tvalid && m_axis_tuser))
    else $error("absorbing began without an early-exit result");

endmodule

`default_nettype wire
